>>> hw/rtl/cd_pkg.sv
// Shared types and codes for the circular deque.
package cd_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;

  // Command codes carried in the input tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_e;

  // Status codes carried in the output tuser.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_PUSH_FRONT,
    CELL_PUSH_BACK,
    CELL_POP_FRONT,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic signed [WORD_W-1:0]  value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/cd_cell.sv
// One storage cell of the deque chain, exchanging its word with its neighbours.
module cd_cell #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned IDX   = 0
) (
  input  logic                                 clk_i,
  input  cd_pkg::cell_ctrl_t                   ctrl_i,
  input  logic [$clog2(DEPTH+1)-1:0]           occ_i,
  input  logic signed [cd_pkg::WORD_W-1:0]     left_i,
  input  logic signed [cd_pkg::WORD_W-1:0]     right_i,
  input  logic signed [cd_pkg::WORD_W-1:0]     front_i,
  output logic signed [cd_pkg::WORD_W-1:0]     data_o
);

  localparam int unsigned OW = $clog2(DEPTH + 1);

  logic signed [cd_pkg::WORD_W-1:0] data_q, data_d;
  logic                             is_free, is_tail;

  // The first free cell sits at the occupancy, the back word just below it.
  assign is_free = (occ_i == OW'(IDX));
  assign is_tail = (occ_i == OW'(IDX + 1));

  // Next word for this cell according to the broadcast operation.
  always_comb begin
    data_d = data_q;
    case (ctrl_i.op)
      cd_pkg::CELL_PUSH_FRONT: data_d = left_i;
      cd_pkg::CELL_PUSH_BACK: begin
        if (is_free) data_d = ctrl_i.value;
      end
      cd_pkg::CELL_POP_FRONT: data_d = right_i;
      cd_pkg::CELL_ROTATE: begin
        if (is_tail) data_d = front_i;
        else         data_d = right_i;
      end
      default: data_d = data_q;
    endcase
  end

  // Contents are undefined until written, so the word has no reset.
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

>>> hw/rtl/circular_deque.sv
// Double-ended queue of signed words held in a chain of storage cells.
// Each result is written into the output register on its transfer and appears in the cycle after.
// Throughput: push and pop accept one item per cycle while the output is taken and no dump is running.
// A dump of N words emits them one word per cycle while the output is taken, by rotating the cell chain.
// Reset clears the occupancy, the dump state and the output valid; cell contents are
// left undefined and are only read after they have been written.
module circular_deque #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic signed [cd_pkg::WORD_W-1:0]  s_axis_tdata,  // value
  input  logic [cd_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic signed [cd_pkg::WORD_W-1:0]  m_axis_tdata,  // word
  output logic [cd_pkg::STATUS_W-1:0]       m_axis_tuser,  // status
  output logic                              m_axis_tlast   // last
);

  localparam int unsigned OW = $clog2(DEPTH + 1);
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_e;

  state_e                           state_q, state_d;
  logic [OW-1:0]                    occ_q, occ_d;
  logic [OW-1:0]                    remain_q, remain_d;
  logic                             out_valid_q;
  logic signed [cd_pkg::WORD_W-1:0] out_word_q;
  logic [cd_pkg::STATUS_W-1:0]      out_status_q;
  logic                             out_last_q;

  logic                             out_free, in_fire, full, empty;
  logic [IW-1:0]                    tail_idx;
  logic                             emit, emit_last;
  cd_pkg::status_e                  emit_status;
  logic signed [cd_pkg::WORD_W-1:0] emit_word;
  cd_pkg::cell_ctrl_t               ctrl;
  logic signed [cd_pkg::WORD_W-1:0] cell_data [DEPTH];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign full          = (occ_q == OW'(DEPTH));
  assign empty         = (occ_q == '0);
  assign tail_idx      = IW'(occ_q - OW'(1));

  // Command decode and dump sequencing.
  always_comb begin
    ctrl.op     = cd_pkg::CELL_HOLD;
    ctrl.value  = s_axis_tdata;
    occ_d       = occ_q;
    remain_d    = remain_q;
    state_d     = state_q;
    emit        = 1'b0;
    emit_status = cd_pkg::STATUS_OK;
    emit_word   = '0;
    emit_last   = 1'b1;
    if (in_fire) begin
      case (cd_pkg::cmd_e'(s_axis_tuser))
        cd_pkg::CMD_PUSH_FRONT, cd_pkg::CMD_PUSH_BACK: begin
          emit = 1'b1;
          if (full) begin
            emit_status = cd_pkg::STATUS_FULL;
          end else begin
            ctrl.op = (cd_pkg::cmd_e'(s_axis_tuser) == cd_pkg::CMD_PUSH_FRONT) ?
                      cd_pkg::CELL_PUSH_FRONT : cd_pkg::CELL_PUSH_BACK;
            occ_d   = occ_q + OW'(1);
          end
        end
        cd_pkg::CMD_POP_FRONT, cd_pkg::CMD_POP_BACK: begin
          emit = 1'b1;
          if (empty) begin
            emit_status = cd_pkg::STATUS_EMPTY;
          end else begin
            if (cd_pkg::cmd_e'(s_axis_tuser) == cd_pkg::CMD_POP_FRONT) begin
              emit_word = cell_data[0];
              ctrl.op   = cd_pkg::CELL_POP_FRONT;
            end else begin
              emit_word = cell_data[tail_idx];
            end
            occ_d = occ_q - OW'(1);
          end
        end
        cd_pkg::CMD_DUMP: begin
          emit = 1'b1;
          if (empty) begin
            emit_status = cd_pkg::STATUS_EMPTY;
          end else begin
            emit_word = cell_data[0];
            ctrl.op   = cd_pkg::CELL_ROTATE;
            emit_last = (occ_q == OW'(1));
            remain_d  = occ_q - OW'(1);
            if (occ_q != OW'(1)) state_d = ST_DUMP;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end else if (state_q == ST_DUMP && out_free) begin
      // Each rotation brings the next word to the front cell.
      emit      = 1'b1;
      emit_word = cell_data[0];
      ctrl.op   = cd_pkg::CELL_ROTATE;
      emit_last = (remain_q == OW'(1));
      remain_d  = remain_q - OW'(1);
      if (remain_q == OW'(1)) state_d = ST_IDLE;
    end
  end

  // State, occupancy and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      occ_q        <= '0;
      remain_q     <= '0;
      out_valid_q  <= 1'b0;
      out_word_q   <= '0;
      out_status_q <= '0;
      out_last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      occ_q    <= occ_d;
      remain_q <= remain_d;
      if (emit) begin
        out_valid_q  <= 1'b1;
        out_word_q   <= emit_word;
        out_status_q <= emit_status;
        out_last_q   <= emit_last;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The chain of cells, front word in cell zero.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [cd_pkg::WORD_W-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = s_axis_tdata;
    end else begin : g_inner_l
      assign left_w = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = cell_data[g+1];
    end
    cd_cell #(
      .DEPTH (DEPTH),
      .IDX   (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .occ_i   (occ_q),
      .left_i  (left_w),
      .right_i (right_w),
      .front_i (cell_data[0]),
      .data_o  (cell_data[g])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;

endmodule

>>> hw/rtl/cd_checker.sv
// Port-level checks for the circular deque and their binding to the top level.
module cd_port_checks (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [cd_pkg::CMD_W-1:0]          s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic signed [cd_pkg::WORD_W-1:0]  m_axis_tdata,
  input logic [cd_pkg::STATUS_W-1:0]       m_axis_tuser,
  input logic                              m_axis_tlast
);

  logic in_fire, single_cmd;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign single_cmd = (s_axis_tuser == cd_pkg::CMD_PUSH_FRONT) ||
                      (s_axis_tuser == cd_pkg::CMD_PUSH_BACK) ||
                      (s_axis_tuser == cd_pkg::CMD_POP_FRONT) ||
                      (s_axis_tuser == cd_pkg::CMD_POP_BACK);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("output transfer changed while stalled");

  // No new item is taken while a result waits unaccepted.
  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // Push and pop give exactly one result in the next cycle.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && single_cmd |=> m_axis_tvalid && m_axis_tlast)
    else $error("push or pop result missing or not marked last");

  // Full and empty results carry a zero word and close the item.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != cd_pkg::STATUS_OK) |->
      (m_axis_tdata == '0) && m_axis_tlast)
    else $error("full or empty result with data or without last");

endmodule

bind circular_deque cd_port_checks u_cd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

>>> sim/cd_checker.sv
// Checker for the circular deque: predicts every result and compares it on arrival.
module cd_checker #(
  parameter int unsigned DEPTH = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  input  logic                               s_axis_tready,
  input  logic signed [cd_pkg::WORD_W-1:0]   s_axis_tdata,  // value
  input  logic [cd_pkg::CMD_W-1:0]           s_axis_tuser,  // cmd
  input  logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  input  logic signed [cd_pkg::WORD_W-1:0]   m_axis_tdata,  // word
  input  logic [cd_pkg::STATUS_W-1:0]        m_axis_tuser,  // status
  input  logic                               m_axis_tlast,  // last
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        commands_o,
  output int unsigned                        results_o,
  output int unsigned                        full_seen_o,
  output int unsigned                        empty_seen_o,
  output int unsigned                        longest_dump_o
);

  // One result as the block should present it.
  typedef struct packed {
    cd_pkg::status_e                   status;
    logic signed [cd_pkg::WORD_W-1:0]  word;
    logic                              last;
  } deque_result_t;

  // Shadow copy of the deque contents and pointers.
  logic signed [cd_pkg::WORD_W-1:0] deque_store [DEPTH];
  int unsigned                      front_idx;
  int unsigned                      back_idx;
  int unsigned                      fill_level;
  deque_result_t                    awaited_results [$];

  // Work out the results of one command and update the shadow deque.
  task automatic predict_deque_op(input logic [cd_pkg::CMD_W-1:0] cmd,
                                  input logic signed [cd_pkg::WORD_W-1:0] value);
    deque_result_t res;
    int unsigned   pos;
    res = '{status: cd_pkg::STATUS_OK, word: '0, last: 1'b1};
    case (cmd)
      cd_pkg::CMD_PUSH_FRONT, cd_pkg::CMD_PUSH_BACK: begin
        if (fill_level >= DEPTH) begin
          res.status = cd_pkg::STATUS_FULL;
          full_seen_o++;
        end else begin
          if (fill_level == 0) begin
            front_idx      = 0;
            back_idx       = 0;
            deque_store[0] = value;
          end else if (cmd == cd_pkg::CMD_PUSH_FRONT) begin
            front_idx              = (front_idx == 0) ? DEPTH - 1 : front_idx - 1;
            deque_store[front_idx] = value;
          end else begin
            back_idx              = (back_idx + 1 == DEPTH) ? 0 : back_idx + 1;
            deque_store[back_idx] = value;
          end
          fill_level++;
        end
        awaited_results.push_back(res);
      end
      cd_pkg::CMD_POP_FRONT, cd_pkg::CMD_POP_BACK: begin
        if (fill_level == 0) begin
          res.status = cd_pkg::STATUS_EMPTY;
          empty_seen_o++;
        end else begin
          if (cmd == cd_pkg::CMD_POP_FRONT) begin
            res.word  = deque_store[front_idx];
            front_idx = (front_idx + 1 == DEPTH) ? 0 : front_idx + 1;
          end else begin
            res.word = deque_store[back_idx];
            back_idx = (back_idx == 0) ? DEPTH - 1 : back_idx - 1;
          end
          fill_level--;
          // Popping the only word leaves both pointers at the first entry.
          if (fill_level == 0) begin
            front_idx = 0;
            back_idx  = 0;
          end
        end
        awaited_results.push_back(res);
      end
      cd_pkg::CMD_DUMP: begin
        if (fill_level == 0) begin
          res.status = cd_pkg::STATUS_EMPTY;
          empty_seen_o++;
          awaited_results.push_back(res);
        end else begin
          pos = front_idx;
          for (int unsigned n = 0; n < fill_level; n++) begin
            res.word = deque_store[pos];
            res.last = (n + 1 == fill_level);
            awaited_results.push_back(res);
            pos = (pos + 1 == DEPTH) ? 0 : pos + 1;
          end
          if (fill_level > longest_dump_o) longest_dump_o = fill_level;
        end
      end
      // Spare command codes leave the deque alone and produce nothing.
      default: ;
    endcase
  endtask

  // Results are compared before this edge's command is predicted, so a result
  // can never be matched against a command accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp;
    if (!rst_ni) begin
      front_idx      = 0;
      back_idx       = 0;
      fill_level     = 0;
      awaited_results.delete();
      fail_count_o   = 0;
      pending_o      = 0;
      commands_o     = 0;
      results_o      = 0;
      full_seen_o    = 0;
      empty_seen_o   = 0;
      longest_dump_o = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected result transfer: status %0d word %0d last %0b",
                   $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
        end else begin
          exp = awaited_results.pop_front();
          if (m_axis_tuser !== exp.status) begin
            fail_count_o++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, exp.status, m_axis_tuser);
          end
          if (m_axis_tdata !== exp.word) begin
            fail_count_o++;
            $display("%0t: word mismatch: expected %0d, got %0d",
                     $time, exp.word, m_axis_tdata);
          end
          if (m_axis_tlast !== exp.last) begin
            fail_count_o++;
            $display("%0t: last mismatch: expected %0b, got %0b",
                     $time, exp.last, m_axis_tlast);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        commands_o++;
        predict_deque_op(s_axis_tuser, s_axis_tdata);
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

>>> sim/tb_top.sv
// Top of the circular deque testbench: clock, reset, stimulus and verdict.
module tb_top;

  typedef logic [cd_pkg::CMD_W-1:0] cmd_t;

  localparam int unsigned DEPTH           = 8;
  localparam int unsigned RANDOM_ITEMS    = 85;
  localparam cmd_t        FIRST_SPARE_CMD = 3'd5;

  logic                              clk_i  = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic signed [cd_pkg::WORD_W-1:0]  s_axis_tdata  = '0;               // value
  logic [cd_pkg::CMD_W-1:0]          s_axis_tuser  = cd_pkg::CMD_DUMP; // cmd
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic signed [cd_pkg::WORD_W-1:0]  m_axis_tdata;                     // word
  logic [cd_pkg::STATUS_W-1:0]       m_axis_tuser;                     // status
  logic                              m_axis_tlast;                     // last

  // Set during a stretch of the run in which neither side stalls at random.
  logic steady = 1'b0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned commands;
  int unsigned results;
  int unsigned full_seen;
  int unsigned empty_seen;
  int unsigned longest_dump;

  always #10 clk_i = ~clk_i;

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  cd_checker #(.DEPTH(DEPTH)) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .commands_o     (commands),
    .results_o      (results),
    .full_seen_o    (full_seen),
    .empty_seen_o   (empty_seen),
    .longest_dump_o (longest_dump)
  );

  // The result side stalls at random except during the steady stretch.
  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 18);
  end

  // Offer one command and hold it until its transfer; returns at a falling edge.
  task automatic send_item(input logic [cd_pkg::CMD_W-1:0] cmd,
                           input logic signed [cd_pkg::WORD_W-1:0] value);
    while (!steady && $urandom_range(0, 99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off new commands until every outstanding result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned                      sent;
    int unsigned                      push_pct;
    int unsigned                      roll;
    logic [cd_pkg::CMD_W-1:0]         cmd;
    logic signed [cd_pkg::WORD_W-1:0] value;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty deque: both pops and a dump report empty; spare codes are ignored.
    send_item(cd_pkg::CMD_POP_FRONT, 32'sd0);
    send_item(cd_pkg::CMD_POP_BACK, -32'sd1);
    send_item(cd_pkg::CMD_DUMP, 32'sd0);
    for (int k = 0; k < 3; k++) send_item(FIRST_SPARE_CMD + cmd_t'(k), $urandom());

    // Push into an empty deque, then pop that only word from the other end.
    send_item(cd_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_item(cd_pkg::CMD_POP_BACK, 32'sd0);

    // Fill from both ends with the extreme words, so the pointers wrap.
    send_item(cd_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(cd_pkg::CMD_PUSH_FRONT, -32'sd1);
    send_item(cd_pkg::CMD_PUSH_FRONT, 32'sd0);
    send_item(cd_pkg::CMD_PUSH_BACK, 32'sd1);
    send_item(cd_pkg::CMD_PUSH_BACK, 32'h5555_5555);
    send_item(cd_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_item(cd_pkg::CMD_PUSH_BACK, 32'h8000_0000);
    send_item(cd_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFF);

    // Full deque: both pushes are refused, then a full dump, two pops and a dump of the rest.
    send_item(cd_pkg::CMD_PUSH_FRONT, 32'sd12345);
    send_item(cd_pkg::CMD_PUSH_BACK, -32'sd12345);
    send_item(cd_pkg::CMD_DUMP, 32'sd0);
    send_item(cd_pkg::CMD_POP_FRONT, 32'sd0);
    send_item(cd_pkg::CMD_POP_BACK, 32'sd0);
    send_item(cd_pkg::CMD_DUMP, 32'sd0);
    drain_results();

    // Random commands in bursts that lean towards filling, draining or neither.
    sent     = 0;
    push_pct = 45;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 10 == 0) begin
        roll     = $urandom_range(0, 2);
        push_pct = (roll == 0) ? 70 : (roll == 1) ? 25 : 45;
      end
      steady = (sent >= 40 && sent < 75);
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        cmd = FIRST_SPARE_CMD + cmd_t'($urandom_range(0, 2));
      end else if (roll < 15) begin
        cmd = cd_pkg::CMD_DUMP;
      end else if (roll < 15 + push_pct) begin
        cmd = $urandom_range(0, 1) ? cd_pkg::CMD_PUSH_FRONT : cd_pkg::CMD_PUSH_BACK;
      end else begin
        cmd = $urandom_range(0, 1) ? cd_pkg::CMD_POP_FRONT : cd_pkg::CMD_POP_BACK;
      end
      case ($urandom_range(0, 7))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = -32'sd1;
        3:       value = 32'sd0;
        default: value = $urandom();
      endcase
      send_item(cmd, value);
      if (cmd < FIRST_SPARE_CMD) begin
        sent++;
        if (sent == 60) drain_results();
      end
    end
    steady = 1'b0;

    // Let the last results drain, then wait on for anything stray.
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Covered %0d commands and %0d results, with %0d full refusals,",
             commands, results, full_seen);
    $display("%0d empty statuses and dumps of up to %0d words.", empty_seen, longest_dump);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #2000000;
    $display("Timeout with %0d results still awaited.", pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/cd_pkg.sv
hw/rtl/cd_cell.sv
hw/rtl/circular_deque.sv
hw/rtl/cd_checker.sv
sim/cd_checker.sv
sim/tb_top.sv
